@@ rtl/lzw_gif_pixel_compressor_macros.svh @@
// Assertion macros shared by the LZW compressor RTL.
`ifndef LZW_GIF_PIXEL_COMPRESSOR_MACROS_SVH
`define LZW_GIF_PIXEL_COMPRESSOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on the rising clock, off during reset.
`define LZW_ASSERT_IMP(name, clk, rst_n, ant, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on the rising clock, off during reset.
`define LZW_ASSERT_NXT(name, clk, rst_n, ant, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);
`else
`define LZW_ASSERT_IMP(name, clk, rst_n, ant, cons, msg)
`define LZW_ASSERT_NXT(name, clk, rst_n, ant, cons, msg)
`endif
`endif

@@ rtl/lzw_pkg.sv @@
// Shared constants and types of the LZW pixel compressor.
package lzw_pkg;

  localparam int HASH_DEPTH = 5003;
  localparam int HASH_AW    = $clog2(HASH_DEPTH);
  localparam int MAX_CODE   = 4095;
  localparam int WIDEST     = 12;
  localparam int ENTRY_W    = 32;

  // Bit packer commands.
  typedef enum logic [1:0] {
    PK_NONE,
    PK_PUT,
    PK_FLUSH
  } pk_op_e;

  // One request from the sequencer to the bit packer.
  typedef struct packed {
    pk_op_e      op;
    logic        fin;
    logic [11:0] code;
    logic [3:0]  width;
  } pk_cmd_t;

endpackage

@@ rtl/lzw_dict_ram.sv @@
// Single-port dictionary memory with registered read data.
module lzw_dict_ram #(
  parameter int DEPTH = 5003,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

@@ rtl/lzw_bit_packer.sv @@
// Packs variable-width codes LSB-first into bytes behind an output register.
module lzw_bit_packer
  import lzw_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pk_cmd_t       cmd_i,
  output logic          idle_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          last_byte_o
);

  logic [18:0] acc_q, acc_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [6:0]  pend_q, pend_d;
  logic [2:0]  pcnt_q, pcnt_d;
  logic        busy_q, busy_d;
  logic        fin_q, fin_d;
  logic        ovld_q, ovld_d;
  logic [7:0]  obyte_q, obyte_d;
  logic        olast_q, olast_d;
  logic [11:0] mask;
  logic        slot_free;

  assign idle_o      = !busy_q;
  assign out_valid_o = ovld_q;
  assign out_byte_o  = obyte_q;
  assign last_byte_o = olast_q;
  assign slot_free   = !ovld_q || out_ready_i;
  assign mask        = 12'((13'd1 << cmd_i.width) - 13'd1);

  // Load a code or a flush, then drain whole bytes one per cycle while the output slot is free.
  always_comb begin
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    pend_d  = pend_q;
    pcnt_d  = pcnt_q;
    busy_d  = busy_q;
    fin_d   = fin_q;
    ovld_d  = ovld_q && !out_ready_i;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (busy_q) begin
      if (cnt_q >= 5'd8) begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          obyte_d = acc_q[7:0];
          olast_d = fin_q && (cnt_q == 5'd8);
          acc_d   = acc_q >> 8;
          cnt_d   = cnt_q - 5'd8;
        end
      end else begin
        pend_d = acc_q[6:0];
        pcnt_d = cnt_q[2:0];
        busy_d = 1'b0;
      end
    end else begin
      case (cmd_i.op)
        PK_PUT: begin
          acc_d  = 19'(pend_q) | (19'(cmd_i.code & mask) << pcnt_q);
          cnt_d  = 5'(pcnt_q) + 5'(cmd_i.width);
          fin_d  = cmd_i.fin;
          busy_d = 1'b1;
        end
        PK_FLUSH: begin
          acc_d  = (pcnt_q != 3'd0) ? 19'(pend_q) : 19'd0;
          cnt_d  = (pcnt_q != 3'd0) ? 5'd8 : 5'd0;
          fin_d  = 1'b1;
          busy_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ovld_q <= 1'b0;
      pend_q <= 7'd0;
      pcnt_q <= 3'd0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ovld_q <= ovld_d;
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
      fin_q  <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    cnt_q   <= cnt_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

endmodule

@@ rtl/lzw_gif_pixel_compressor.sv @@
// LZW pixel compressor: an accepted pixel, bar the first of an image, keeps the block busy
// through hash, read and compare; each further probe repeats the read and compare. A miss
// emits the prefix and updates the dictionary. Each code first waits for the packer, which
// stays busy draining whole bytes and stalls while one is not taken. The last pixel of an
// image, and a table reset when codes run out, start a pass clearing all 5003 dictionary
// entries. Reset, asynchronous and active low, starts the same pass; no pixel is taken in it.
`include "lzw_gif_pixel_compressor_macros.svh"
module lzw_gif_pixel_compressor
  import lzw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] min_code_size_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] pixel_i,
  input  logic       last_pixel_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_PUT, S_SETPFX, S_CHKLAST, S_PUTEND,
    S_FLUSH, S_HASH, S_RD, S_CMP, S_UPD, S_REINIT
  } state_e;

  state_e              state_q, state_d, ret_q, ret_d, cret_q, cret_d;
  logic [HASH_AW-1:0]  clr_addr_q, clr_addr_d;
  logic [3:0]          mcs_q, mcs_d;
  logic [7:0]          pix_q, pix_d;
  logic                last_q, last_d, have_q, have_d, slot_ok_q, slot_ok_d;
  logic [11:0]         prefix_q, prefix_d, put_code_q, put_code_d;
  logic                put_fin_q, put_fin_d;
  logic [3:0]          width_q, width_d;
  logic [12:0]         nfc_q, nfc_d, limit_q, limit_d;
  logic [HASH_AW-1:0]  hx_q, hx_d, dst_q, dst_d, k_q, k_d;

  logic [3:0]          root_w;
  logic [8:0]          clear_code;
  logic [13:0]         probe_sum, step_sum;
  logic [12:0]         hash_raw;
  logic                ram_we;
  logic [HASH_AW-1:0]  ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  pk_cmd_t             pk_cmd;
  logic                pk_idle;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  // Root width saturated into its legal range.
  always_comb begin
    root_w = mcs_q;
    if (mcs_q < 4'd2) root_w = 4'd2;
    if (mcs_q > 4'd8) root_w = 4'd8;
  end
  assign clear_code = 9'(10'd1 << root_w);

  // Hash start value and the separate sums for the probe walk.
  assign hash_raw  = 13'(prefix_q) ^ (13'(pix_q) << 5);
  assign probe_sum = 14'(hx_q) + 14'(dst_q);
  assign step_sum  = 14'(dst_q) + 14'd2;

  lzw_dict_ram #(
    .DEPTH(HASH_DEPTH),
    .WIDTH(ENTRY_W),
    .AW   (HASH_AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  lzw_bit_packer u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pk_cmd),
    .idle_o     (pk_idle),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .last_byte_o(last_byte_o)
  );

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cret_d     = cret_q;
    clr_addr_d = clr_addr_q;
    mcs_d      = mcs_q;
    pix_d      = pix_q;
    last_d     = last_q;
    have_d     = have_q;
    slot_ok_d  = slot_ok_q;
    prefix_d   = prefix_q;
    put_code_d = put_code_q;
    put_fin_d  = put_fin_q;
    width_d    = width_q;
    nfc_d      = nfc_q;
    limit_d    = limit_q;
    hx_d       = hx_q;
    dst_d      = dst_q;
    k_d        = k_q;
    ram_we     = 1'b0;
    ram_addr   = hx_q;
    ram_wdata  = '0;
    pk_cmd     = '{op: PK_NONE, fin: 1'b0, code: 12'd0, width: width_q};

    if (cfg_valid_i) begin
      mcs_d = min_code_size_i;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr_q;
        if (clr_addr_q == HASH_AW'(HASH_DEPTH - 1)) begin
          clr_addr_d = '0;
          state_d    = cret_q;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          pix_d   = pixel_i & clear_code[7:0] - 8'd1 | (clear_code[8] ? 8'hff : 8'h00)
                    & pixel_i;
          last_d  = last_pixel_i;
          state_d = have_q ? S_HASH : S_START;
        end
      end
      S_START: begin
        width_d    = root_w + 4'd1;
        nfc_d      = 13'(clear_code) + 13'd2;
        limit_d    = 13'd1 << (root_w + 4'd1);
        have_d     = 1'b1;
        put_code_d = 12'(clear_code);
        put_fin_d  = 1'b0;
        ret_d      = S_SETPFX;
        state_d    = S_PUT;
      end
      S_PUT: begin
        if (pk_idle) begin
          pk_cmd  = '{op: PK_PUT, fin: put_fin_q, code: put_code_q, width: width_q};
          state_d = ret_q;
        end
      end
      S_SETPFX: begin
        prefix_d = 12'(pix_q);
        state_d  = S_CHKLAST;
      end
      S_CHKLAST: begin
        if (last_q) begin
          put_code_d = prefix_q;
          put_fin_d  = 1'b0;
          ret_d      = S_PUTEND;
          state_d    = S_PUT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_PUTEND: begin
        put_code_d = 12'(clear_code) + 12'd1;
        put_fin_d  = 1'b1;
        ret_d      = S_FLUSH;
        state_d    = S_PUT;
      end
      S_FLUSH: begin
        if (pk_idle) begin
          pk_cmd  = '{op: PK_FLUSH, fin: 1'b1, code: 12'd0, width: width_q};
          have_d  = 1'b0;
          cret_d  = S_IDLE;
          state_d = S_CLEAR;
        end
      end
      S_HASH: begin
        hx_d    = (hash_raw >= 13'(HASH_DEPTH)) ? 13'(hash_raw - 13'(HASH_DEPTH)) : hash_raw;
        dst_d   = HASH_AW'(1);
        k_d     = '0;
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (ram_rdata[11:0] == 12'd0) begin
          slot_ok_d  = 1'b1;
          put_code_d = prefix_q;
          put_fin_d  = 1'b0;
          ret_d      = S_UPD;
          state_d    = S_PUT;
        end else if (ram_rdata[23:12] == prefix_q && ram_rdata[31:24] == pix_q) begin
          prefix_d = ram_rdata[11:0];
          state_d  = S_CHKLAST;
        end else if (k_q == HASH_AW'(HASH_DEPTH - 1)) begin
          slot_ok_d  = 1'b0;
          put_code_d = prefix_q;
          put_fin_d  = 1'b0;
          ret_d      = S_UPD;
          state_d    = S_PUT;
        end else begin
          k_d     = k_q + 1'b1;
          hx_d    = (probe_sum >= 14'(HASH_DEPTH)) ? HASH_AW'(probe_sum - 14'(HASH_DEPTH))
                                                   : HASH_AW'(probe_sum);
          dst_d   = (step_sum >= 14'(HASH_DEPTH)) ? HASH_AW'(step_sum - 14'(HASH_DEPTH))
                                                  : HASH_AW'(step_sum);
          state_d = S_RD;
        end
      end
      S_UPD: begin
        // Add the new string, widen the code, or start a fresh table.
        if (nfc_q <= 13'(MAX_CODE)) begin
          if (slot_ok_q) begin
            ram_we    = 1'b1;
            ram_wdata = {pix_q, prefix_q, nfc_q[11:0]};
          end
          nfc_d = nfc_q + 13'd1;
        end
        if (nfc_q == limit_q && width_q < 4'(WIDEST)) begin
          width_d = width_q + 4'd1;
          limit_d = limit_q << 1;
        end
        if (nfc_q > 13'(MAX_CODE)) begin
          put_code_d = 12'(clear_code);
          put_fin_d  = 1'b0;
          ret_d      = S_REINIT;
          state_d    = S_PUT;
        end else begin
          state_d = S_SETPFX;
        end
      end
      S_REINIT: begin
        width_d = root_w + 4'd1;
        nfc_d   = 13'(clear_code) + 13'd2;
        limit_d = 13'd1 << (root_w + 4'd1);
        cret_d  = S_SETPFX;
        state_d = S_CLEAR;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      ret_q      <= S_IDLE;
      cret_q     <= S_IDLE;
      clr_addr_q <= '0;
      mcs_q      <= 4'd8;
      have_q     <= 1'b0;
      prefix_q   <= 12'd0;
      width_q    <= 4'd9;
      nfc_q      <= 13'd258;
      limit_q    <= 13'd512;
      last_q     <= 1'b0;
      slot_ok_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      cret_q     <= cret_d;
      clr_addr_q <= clr_addr_d;
      mcs_q      <= mcs_d;
      have_q     <= have_d;
      prefix_q   <= prefix_d;
      width_q    <= width_d;
      nfc_q      <= nfc_d;
      limit_q    <= limit_d;
      last_q     <= last_d;
      slot_ok_q  <= slot_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    put_code_q <= put_code_d;
    put_fin_q  <= put_fin_d;
    hx_q       <= hx_d;
    dst_q      <= dst_d;
    k_q        <= k_d;
  end

  // In the cycle after a pixel is accepted, the block is not ready for another.
  `LZW_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni,
                  in_valid_i && in_ready_o, !in_ready_o, "pixel accepted back to back")
  // No pixel is taken while the dictionary is being cleared.
  `LZW_ASSERT_IMP(a_no_accept_in_clear, clk_i, rst_ni,
                  state_q == S_CLEAR, !in_ready_o, "ready during clearing pass")
  // Code width stays within the legal range.
  `LZW_ASSERT_IMP(a_width_range, clk_i, rst_ni,
                  1'b1, width_q >= 4'd3 && width_q <= 4'(WIDEST), "code width out of range")
  // The free code counter stops one past the largest code.
  `LZW_ASSERT_IMP(a_nfc_bound, clk_i, rst_ni,
                  1'b1, nfc_q <= 13'(MAX_CODE + 1), "free code overran")

endmodule

@@ sim/lzw_gif_pixel_compressor_tb.sv @@
// Self-checking testbench for the LZW GIF pixel compressor, with a built-in code stream predictor.
`timescale 1ns / 100ps

module lzw_gif_pixel_compressor_tb
  import lzw_pkg::*;
();

  // Cycles to let the dictionary clearing pass finish before touching the register.
  localparam int ClearWait = HASH_DEPTH + 1000;
  // Length of the commanded receiver hold-off in cycles.
  localparam int LongHold  = 600;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [3:0] min_code_size_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] pixel_i;
  logic       last_pixel_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_byte_o;
  logic       last_byte_o;

  // Predicted encoder state.
  logic [31:0] dict_mem [HASH_DEPTH];
  int unsigned cur_prefix;
  bit          in_image;
  int unsigned cur_width;
  int unsigned free_code;
  int unsigned grow_at;
  int unsigned bit_acc;
  int unsigned bit_cnt;
  logic [3:0]  min_code_reg;
  byte_t       step_bytes[$];

  byte_t       byte_q[$];
  int          errors;
  bit          tx_burst;
  bit          rx_burst;
  int          rx_hold = 0;
  int          rx_req  = 0;
  int          rx_seen = 0;

  lzw_gif_pixel_compressor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .min_code_size_i(min_code_size_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pixel_i        (pixel_i),
    .last_pixel_i   (last_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_byte_o    (last_byte_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Root code width after saturation into the legal range.
  function automatic int unsigned root_bits();
    int unsigned m;
    m = min_code_reg;
    if (m < 2) m = 2;
    if (m > 8) m = 8;
    return m;
  endfunction

  function automatic void reset_table();
    int unsigned m;
    m = root_bits();
    cur_width = m + 1;
    free_code = (1 << m) + 2;
    grow_at   = 1 << cur_width;
    for (int i = 0; i < HASH_DEPTH; i++) dict_mem[i] = '0;
  endfunction

  // Append a code LSB-first and collect every completed byte.
  function automatic void pack_code(int unsigned code);
    int unsigned acc;
    int unsigned cnt;
    byte_t b;
    acc = (bit_acc & 32'h7f) | ((code & ((1 << cur_width) - 1)) << bit_cnt);
    cnt = bit_cnt + cur_width;
    while (cnt >= 8) begin
      b.data = acc[7:0];
      b.fin  = 1'b0;
      step_bytes.push_back(b);
      acc = acc >> 8;
      cnt -= 8;
    end
    bit_acc = acc & 32'h7f;
    bit_cnt = cnt & 7;
  endfunction

  // Dictionary lookup of (prefix, pixel); a miss emits the prefix and adds an entry.
  function automatic void lookup_pixel(int unsigned pix, int unsigned clear);
    int unsigned hx;
    int unsigned step;
    int unsigned a;
    logic [31:0] e;
    bit slot_ok;
    hx = (cur_prefix ^ (pix << 5)) % HASH_DEPTH;
    step = 1;
    slot_ok = 1'b0;
    for (int k = 0; k < HASH_DEPTH; k++) begin
      e = dict_mem[hx];
      if (e[11:0] == 0) begin
        slot_ok = 1'b1;
        break;
      end
      if (e[23:12] == cur_prefix && e[31:24] == pix) begin
        cur_prefix = e[11:0];
        return;
      end
      hx = (hx + step) % HASH_DEPTH;
      step += 2;
      if (step >= HASH_DEPTH) step -= HASH_DEPTH;
    end
    pack_code(cur_prefix);
    a = free_code;
    if (a <= MAX_CODE) begin
      if (slot_ok) dict_mem[hx] = {pix[7:0], cur_prefix[11:0], a[11:0]};
      free_code = a + 1;
    end
    if (a == grow_at && cur_width < WIDEST) begin
      cur_width++;
      grow_at = grow_at << 1;
    end
    if (a > MAX_CODE) begin
      pack_code(clear);
      reset_table();
    end
    cur_prefix = pix;
  endfunction

  // Work out the bytes that one pixel produces and queue them.
  function automatic void predict_pixel(logic [7:0] pixel, logic last);
    int unsigned clear;
    int unsigned pix;
    byte_t b;
    clear = 1 << root_bits();
    pix = pixel & (clear - 1);
    step_bytes.delete();
    if (!in_image) begin
      reset_table();
      pack_code(clear);
      cur_prefix = pix;
      in_image = 1'b1;
    end else begin
      lookup_pixel(pix, clear);
    end
    if (last) begin
      pack_code(cur_prefix);
      pack_code(clear + 1);
      if (bit_cnt > 0) begin
        b.data = bit_acc[7:0];
        b.fin  = 1'b0;
        step_bytes.push_back(b);
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].fin = 1'b1;
      in_image = 1'b0;
      bit_acc = 0;
      bit_cnt = 0;
    end
    foreach (step_bytes[i]) byte_q.push_back(step_bytes[i]);
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Compare each accepted byte with the oldest predicted one.
  always @(posedge clk_i) begin
    byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (byte_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_byte_o));
      end else begin
        want = byte_q.pop_front();
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("byte %02h, expected %02h", out_byte_o, want.data));
        if (last_byte_o !== want.fin)
          report_mismatch($sformatf("last flag %0b, expected %0b", last_byte_o, want.fin));
      end
    end
  end

  // Receiver: random stalls, bursts, and commanded long hold-offs.
  always @(posedge clk_i) begin
    if (rx_req != rx_seen) begin
      rx_seen     <= rx_req;
      out_ready_i <= 1'b0;
      rx_hold     <= LongHold;
    end else if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_burst) begin
      out_ready_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 2) begin
      out_ready_i <= 1'b0;
      rx_hold <= $urandom_range(20, 60);
    end else begin
      out_ready_i <= ($urandom_range(0, 9) < 8);
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (tx_burst) return 0;
    if (r < 14) return $urandom_range(0, 2);
    if (r < 19) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Offer one pixel and predict its bytes once the transaction completes.
  task automatic send_pixel(logic [7:0] pixel, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_i      <= pixel;
    last_pixel_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_pixel(pixel, last);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk_i);
  endtask

  // Register write once the block has gone quiet, including its clearing pass.
  task automatic write_min_code(logic [3:0] value);
    wait_drain();
    repeat (ClearWait) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    min_code_size_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    min_code_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_image(int len, int unsigned max_pix);
    for (int i = 0; i < len; i++)
      send_pixel(8'($urandom_range(0, max_pix)), i == len - 1);
  endtask

  // Extremes, single-pixel images, wide pixels, out-of-range and mid-image writes.
  task automatic test_directed();
    send_pixel(8'hff, 1'b1);
    write_min_code(4'd2);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'h03, 1'b0);
    send_pixel(8'h03, 1'b0);
    send_pixel(8'h03, 1'b0);
    send_pixel(8'h00, 1'b1);
    write_min_code(4'd0);
    send_pixel(8'h01, 1'b0);
    send_pixel(8'h02, 1'b1);
    write_min_code(4'd15);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hff, 1'b0);
    send_pixel(8'h80, 1'b0);
    // Change the root width while an image is open.
    write_min_code(4'd4);
    send_pixel(8'h5a, 1'b0);
    send_pixel(8'h0f, 1'b0);
    send_pixel(8'h0f, 1'b1);
    write_min_code(4'd1);
    send_pixel(8'h00, 1'b1);
    write_min_code(4'd8);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h00, 1'b1);
  endtask

  // Short images of random length under random root widths.
  task automatic test_random_images();
    int sent;
    int len;
    sent = 0;
    while (sent < 120) begin
      if ($urandom_range(0, 3) == 0) write_min_code(4'($urandom_range(0, 15)));
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      len = $urandom_range(1, 40);
      // Few colors produce long dictionary chains and many hits.
      send_image(len, ($urandom_range(0, 1) == 1) ? 3 : 255);
      sent += len;
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Longer image at the smallest root width, so the code widens several times.
  task automatic test_code_widening();
    write_min_code(4'd2);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    send_image(60, 3);
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Receiver stalls for a long time while pixels keep coming, then a drain pause.
  task automatic test_backpressure();
    write_min_code(4'd3);
    rx_req++;
    tx_burst = 1'b1;
    send_image(60, 255);
    tx_burst = 1'b0;
    wait_drain();
    send_image(20, 255);
  endtask

  initial begin
    errors = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    in_image = 1'b0;
    bit_acc = 0;
    bit_cnt = 0;
    min_code_reg = 4'd8;
    reset_table();
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    min_code_size_i = 4'd8;
    in_valid_i = 1'b0;
    pixel_i = 8'h00;
    last_pixel_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_images();
    test_code_widening();
    test_backpressure();

    wait_drain();
    repeat (ClearWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
